// ===== sv/sm83alu_pkg.sv =====
// shared types and constants of the sm83 eight-bit alu
`default_nettype none
package sm83alu_pkg;

	typedef enum logic [4:0] {
		FN_ADD  = 5'd0,
		FN_ADC  = 5'd1,
		FN_SUB  = 5'd2,
		FN_SBC  = 5'd3,
		FN_AND  = 5'd4,
		FN_XOR  = 5'd5,
		FN_OR   = 5'd6,
		FN_CP   = 5'd7,
		FN_INC  = 5'd8,
		FN_DEC  = 5'd9,
		FN_RLCA = 5'd10,
		FN_RRCA = 5'd11,
		FN_RLA  = 5'd12,
		FN_RRA  = 5'd13,
		FN_DAA  = 5'd14,
		FN_CPL  = 5'd15,
		FN_SCF  = 5'd16,
		FN_CCF  = 5'd17,
		FN_RLC  = 5'd18,
		FN_RRC  = 5'd19,
		FN_RL   = 5'd20,
		FN_RR   = 5'd21,
		FN_SLA  = 5'd22,
		FN_SRA  = 5'd23,
		FN_SWAP = 5'd24,
		FN_SRL  = 5'd25,
		FN_BIT  = 5'd26,
		FN_RES  = 5'd27,
		FN_SET  = 5'd28
	} alu_func_t;

	typedef logic [4:0] func_t;
	typedef logic [7:0] byte_t;
	typedef logic [2:0] bit_idx_t;
	typedef logic [3:0] flags_t;

	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	localparam byte_t DAA_HI_ADJ = 8'h60;
	localparam byte_t DAA_LO_ADJ = 8'h06;
	localparam byte_t DAA_HI_MAX = 8'h99;
	localparam logic [3:0] DAA_LO_MAX = 4'h9;

endpackage
`default_nettype wire

// ===== sv/sm83alu_req_if.sv =====
// request channel of the sm83 alu: operation, operands and flags
`default_nettype none
interface sm83alu_req_if;
	import sm83alu_pkg::*;

	logic     valid;
	logic     ready;
	func_t    func;
	byte_t    operand_a;
	byte_t    operand_b;
	bit_idx_t bit_sel;
	flags_t   flags_in;

	modport source (output valid, func, operand_a, operand_b, bit_sel, flags_in,
		input ready);
	modport sink (input valid, func, operand_a, operand_b, bit_sel, flags_in,
		output ready);
endinterface
`default_nettype wire

// ===== sv/sm83alu_rsp_if.sv =====
// response channel of the sm83 alu: result byte, flags and write enable
`default_nettype none
interface sm83alu_rsp_if;
	import sm83alu_pkg::*;

	logic   valid;
	logic   ready;
	byte_t  result;
	flags_t flags_out;
	logic   write_result;

	modport source (output valid, result, flags_out, write_result, input ready);
	modport sink (input valid, result, flags_out, write_result, output ready);
endinterface
`default_nettype wire

// ===== sv/sm83_alu_with_flags_core.sv =====
// top level of the sm83 eight-bit alu with flags
// a request passes through the input register and then the result register before its response
// throughput: one request per cycle, limited only by response backpressure
// the alu holds no state between requests; reset clears only the stage valid bits
`default_nettype none
module sm83_alu_with_flags_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	sm83alu_req_if.sink        cmd,
	sm83alu_rsp_if.source      rsp
);
	import sm83alu_pkg::*;

	logic     vld_s1;
	func_t    func_s1;
	byte_t    a_s1;
	byte_t    b_s1;
	bit_idx_t idx_s1;
	flags_t   f_s1;

	logic   vld_s2;
	byte_t  res_s2;
	flags_t flg_s2;
	logic   wr_s2;

	logic ready_s2;
	logic ready_s1;

	logic       cin;
	logic       t;
	logic [8:0] sum9;
	logic [4:0] hsum;
	logic [8:0] dif9;
	logic [4:0] hdif;
	byte_t      bmask;
	byte_t      daa_adj;
	logic       daa_c;
	byte_t      r;
	flags_t     nf;
	logic       wr;

	assign ready_s2  = !vld_s2 || rsp.ready;
	assign ready_s1  = !vld_s1 || ready_s2;
	assign cmd.ready = ready_s1;

	assign rsp.valid        = vld_s2;
	assign rsp.result       = res_s2;
	assign rsp.flags_out    = flg_s2;
	assign rsp.write_result = wr_s2;

	// carry-in for adc/sbc only
	assign cin   = f_s1[FLAG_C];
	assign t     = (func_s1 == FN_ADC || func_s1 == FN_SBC) ? cin : 1'b0;
	assign sum9  = {1'b0, a_s1} + {1'b0, b_s1} + {8'b0, t};
	assign hsum  = {1'b0, a_s1[3:0]} + {1'b0, b_s1[3:0]} + {4'b0, t};
	assign dif9  = {1'b0, a_s1} - {1'b0, b_s1} - {8'b0, t};
	assign hdif  = {1'b0, a_s1[3:0]} - {1'b0, b_s1[3:0]} - {4'b0, t};
	assign bmask = 8'b1 << idx_s1;

	always_comb begin
		daa_adj = 8'h00;
		daa_c   = cin;
		if (!f_s1[FLAG_N]) begin
			if (cin || a_s1 > DAA_HI_MAX) begin
				daa_adj = daa_adj | DAA_HI_ADJ;
				daa_c   = 1'b1;
			end
			if (f_s1[FLAG_H] || a_s1[3:0] > DAA_LO_MAX) begin
				daa_adj = daa_adj | DAA_LO_ADJ;
			end
		end else begin
			if (cin) begin
				daa_adj = daa_adj | DAA_HI_ADJ;
			end
			if (f_s1[FLAG_H]) begin
				daa_adj = daa_adj | DAA_LO_ADJ;
			end
		end
	end

	always_comb begin
		r  = a_s1;
		nf = f_s1;
		wr = 1'b1;
		case (func_s1)
			FN_ADD, FN_ADC: begin
				r  = sum9[7:0];
				nf = {sum9[7:0] == 8'h00, 1'b0, hsum[4], sum9[8]};
			end
			FN_SUB, FN_SBC, FN_CP: begin
				r  = dif9[7:0];
				nf = {dif9[7:0] == 8'h00, 1'b1, hdif[4], dif9[8]};
				wr = (func_s1 != FN_CP);
			end
			FN_AND: begin
				r  = a_s1 & b_s1;
				nf = {(a_s1 & b_s1) == 8'h00, 1'b0, 1'b1, 1'b0};
			end
			FN_XOR: begin
				r  = a_s1 ^ b_s1;
				nf = {(a_s1 ^ b_s1) == 8'h00, 3'b000};
			end
			FN_OR: begin
				r  = a_s1 | b_s1;
				nf = {(a_s1 | b_s1) == 8'h00, 3'b000};
			end
			FN_INC: begin
				r  = a_s1 + 8'd1;
				nf = {a_s1 == 8'hff, 1'b0, a_s1[3:0] == 4'hf, cin};
			end
			FN_DEC: begin
				r  = a_s1 - 8'd1;
				nf = {a_s1 == 8'h01, 1'b1, a_s1[3:0] == 4'h0, cin};
			end
			FN_RLCA, FN_RLC: begin
				r  = {a_s1[6:0], a_s1[7]};
				nf = {(func_s1 == FN_RLC) && (a_s1 == 8'h00), 2'b00, a_s1[7]};
			end
			FN_RRCA, FN_RRC: begin
				r  = {a_s1[0], a_s1[7:1]};
				nf = {(func_s1 == FN_RRC) && (a_s1 == 8'h00), 2'b00, a_s1[0]};
			end
			FN_RLA, FN_RL: begin
				r  = {a_s1[6:0], cin};
				nf = {(func_s1 == FN_RL) && ({a_s1[6:0], cin} == 8'h00), 2'b00, a_s1[7]};
			end
			FN_RRA, FN_RR: begin
				r  = {cin, a_s1[7:1]};
				nf = {(func_s1 == FN_RR) && ({cin, a_s1[7:1]} == 8'h00), 2'b00, a_s1[0]};
			end
			FN_DAA: begin
				r  = f_s1[FLAG_N] ? (a_s1 - daa_adj) : (a_s1 + daa_adj);
				nf = {r == 8'h00, f_s1[FLAG_N], 1'b0, daa_c};
			end
			FN_CPL: begin
				r  = ~a_s1;
				nf = {f_s1[FLAG_Z], 1'b1, 1'b1, cin};
			end
			FN_SCF: begin
				nf = {f_s1[FLAG_Z], 2'b00, 1'b1};
			end
			FN_CCF: begin
				nf = {f_s1[FLAG_Z], 2'b00, !cin};
			end
			FN_SLA: begin
				r  = {a_s1[6:0], 1'b0};
				nf = {a_s1[6:0] == 7'h00, 2'b00, a_s1[7]};
			end
			FN_SRA: begin
				r  = {a_s1[7], a_s1[7:1]};
				nf = {a_s1[7:1] == 7'h00, 2'b00, a_s1[0]};
			end
			FN_SWAP: begin
				r  = {a_s1[3:0], a_s1[7:4]};
				nf = {a_s1 == 8'h00, 3'b000};
			end
			FN_SRL: begin
				r  = {1'b0, a_s1[7:1]};
				nf = {a_s1[7:1] == 7'h00, 2'b00, a_s1[0]};
			end
			FN_BIT: begin
				nf = {!a_s1[idx_s1], 1'b0, 1'b1, cin};
				wr = 1'b0;
			end
			FN_RES: begin
				r = a_s1 & ~bmask;
			end
			FN_SET: begin
				r = a_s1 | bmask;
			end
			default: begin
				wr = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ready_s1) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && ready_s1) begin
			func_s1 <= cmd.func;
			a_s1    <= cmd.operand_a;
			b_s1    <= cmd.operand_b;
			idx_s1  <= cmd.bit_sel;
			f_s1    <= cmd.flags_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (ready_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && ready_s2) begin
			res_s2 <= r;
			flg_s2 <= nf;
			wr_s2  <= wr;
		end
	end

endmodule
`default_nettype wire
